/* sv/ip_blocklist_rate_limit_filter_defines.svh */
// Assertion macros shared by the filter RTL.
`ifndef IP_BLOCKLIST_RATE_LIMIT_FILTER_DEFINES_SVH
`define IP_BLOCKLIST_RATE_LIMIT_FILTER_DEFINES_SVH

// Property that must hold at every rising clock edge outside reset.
`define BRL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked at every rising clock edge, reset included.
`define BRL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/brl_pkg.sv */
// ============================================================================
// brl_pkg
// Types and constants shared by the blocklist and rate limit filter.
// ============================================================================
package brl_pkg;

    localparam int unsigned BlockEntriesDef = 64;
    localparam int unsigned RateEntriesDef  = 64;

    localparam logic [15:0] Ipv4Type    = 16'h0800;
    localparam logic [15:0] EthHdrBytes = 16'd14;
    localparam logic [15:0] EthIpBytes  = 16'd34;
    localparam logic [3:0]  MinIhl      = 4'd5;
    localparam logic [31:0] RateLimitRst    = 32'd1000;
    localparam logic [35:0] WindowLengthRst = 36'd1000000000;

    localparam logic [1:0] CmdPacket = 2'd0;
    localparam logic [1:0] CmdWrite  = 2'd1;
    localparam logic [1:0] CmdRead   = 2'd2;
    localparam logic [1:0] CmdNone   = 2'd3;

    localparam logic [2:0] RsnPass    = 3'd0;
    localparam logic [2:0] RsnBlocked = 3'd1;
    localparam logic [2:0] RsnRate    = 3'd2;
    localparam logic [2:0] RsnParse   = 3'd3;
    localparam logic [2:0] RsnNotIp   = 3'd4;

    localparam logic [1:0] StPassed  = 2'd0;
    localparam logic [1:0] StBlocked = 2'd1;
    localparam logic [1:0] StRate    = 2'd2;
    localparam logic [1:0] StParse   = 2'd3;

    localparam logic [0:0] RegRateLimit = 1'd0;
    localparam logic [0:0] RegWindowLen = 1'd1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] frame_length;
        logic [15:0] ether_type;
        logic [3:0]  header_words;
        logic [31:0] source_address;
        logic [63:0] arrival_time;
        logic [7:0]  block_flag;
        logic [1:0]  counter_select;
    } t_req;

    typedef struct packed {
        logic        drop;
        logic [2:0]  reason;
        logic        write_ok;
        logic [63:0] counter_value;
    } t_rsp;

endpackage

/* sv/brl_stats.sv */
// ============================================================================
// brl_stats
// Four saturating 64-bit event counters with one bump port and a read port.
// ============================================================================
module brl_stats (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_bump,
    input  logic [1:0]  i_bump_sel,
    input  logic [1:0]  i_rd_sel,
    output logic [63:0] o_rd_data
);
    import brl_pkg::*;

    logic [63:0] r_cnt [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_cnt[k] <= '0;
            end
        end else if (i_bump && (r_cnt[i_bump_sel] != '1)) begin
            r_cnt[i_bump_sel] <= r_cnt[i_bump_sel] + 64'd1;
        end
    end

    assign o_rd_data = r_cnt[i_rd_sel];
endmodule

/* sv/ip_blocklist_rate_limit_filter.sv */
// Sequence, acceptance to response handshake: a packet that reaches the rate table
// passes S_SCAN, S_RREAD, S_UPD and S_AGE to S_OUT; a blocklisted packet or a
// blocklist write S_SCAN and S_RREAD; a read, unknown command or rejected header S_SCAN only.
// One request at a time: the next is taken in the cycle after the response
// handshake. Both tables are scanned entry by entry, in parallel.
// Reset: synchronous, active low; clears valid bits, ranks, flags and counters, loads config defaults.
// ============================================================================
// ip_blocklist_rate_limit_filter
// IPv4 source blocklist with a per-source fixed-window rate limiter.
// ============================================================================
`include "ip_blocklist_rate_limit_filter_defines.svh"

module ip_blocklist_rate_limit_filter #(
    parameter int unsigned BLOCK_ENTRIES = brl_pkg::BlockEntriesDef,
    parameter int unsigned RATE_ENTRIES  = brl_pkg::RateEntriesDef
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  brl_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output brl_pkg::t_rsp o_rsp,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);
    import brl_pkg::*;

    localparam int unsigned BW = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
    localparam int unsigned RW = (RATE_ENTRIES > 1) ? $clog2(RATE_ENTRIES) : 1;
    localparam int unsigned RCW = $clog2(RATE_ENTRIES + 1);
    localparam int unsigned NMAX = (BLOCK_ENTRIES > RATE_ENTRIES) ?
                                   BLOCK_ENTRIES : RATE_ENTRIES;
    localparam int unsigned SW = $clog2(NMAX + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_RREAD, S_UPD, S_AGE, S_OUT
    } t_state;

    // ---------------- configuration ----------------
    logic [31:0] r_rate_limit;
    logic [35:0] r_window_len;
    logic        w_cfg_wr;
    logic [0:0]  w_reg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_idx = paddr[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_limit <= RateLimitRst;
            r_window_len <= WindowLengthRst;
        end else if (w_cfg_wr && (paddr[2:0] == 3'd0)) begin
            unique case (w_reg_idx)
                RegRateLimit: r_rate_limit <= pwdata[31:0];
                RegWindowLen: r_window_len <= pwdata[35:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_reg_idx)
            RegRateLimit: prdata = {32'd0, r_rate_limit};
            RegWindowLen: prdata = {28'd0, r_window_len};
            default:      prdata = '0;
        endcase
    end

    // ---------------- tables ----------------
    logic [31:0] r_bkey  [BLOCK_ENTRIES];
    logic [7:0]  r_bflag [BLOCK_ENTRIES];
    logic [BLOCK_ENTRIES-1:0] r_bvalid;
    logic [31:0] r_rkey  [RATE_ENTRIES];
    logic [31:0] r_rcnt  [RATE_ENTRIES];
    logic [63:0] r_wstart[RATE_ENTRIES];
    logic [RW-1:0] r_rank[RATE_ENTRIES];
    logic [RATE_ENTRIES-1:0] r_rvalid;

    // ---------------- sequencer ----------------
    t_state       r_state;
    t_req         r_req;
    t_rsp         r_rsp;
    logic [SW-1:0] r_idx;
    logic [SW-1:0] r_pidx;
    logic         r_pvld;
    logic [31:0]  r_bkey_q, r_rkey_q;
    logic [7:0]   r_bflag_q;
    logic         r_bhit, r_bfree_ok, r_rhit, r_rfree_ok;
    logic [BW-1:0] r_bhit_i, r_bfree_i;
    logic [RW-1:0] r_rhit_i, r_rfree_i, r_vict_i, r_oldest, r_old_rank, r_sel;
    logic [RCW-1:0] r_used;
    logic         r_blocked;
    logic [31:0]  r_cnt_rd;
    logic [63:0]  r_ws_rd;
    logic         w_bump;
    logic [1:0]   w_bump_sel;
    logic [63:0]  w_stat;
    logic         w_parse_err, w_notip;
    logic [BW-1:0] w_bi, w_pbi;
    logic [RW-1:0] w_ri, w_pri;
    logic [63:0]  w_age;
    logic [32:0]  w_cnt_inc;
    logic [31:0]  w_new_cnt;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_rsp   = r_rsp;
    assign w_bi    = r_idx[BW-1:0];
    assign w_ri    = r_idx[RW-1:0];
    assign w_pbi   = r_pidx[BW-1:0];
    assign w_pri   = r_pidx[RW-1:0];

    assign w_parse_err = (r_req.frame_length < EthHdrBytes) ||
                         ((r_req.ether_type == Ipv4Type) &&
                          ((r_req.frame_length < EthIpBytes) ||
                           (r_req.header_words < MinIhl)));
    assign w_notip = (r_req.frame_length >= EthHdrBytes) &&
                     (r_req.ether_type != Ipv4Type);

    assign w_age     = r_req.arrival_time - r_ws_rd;
    assign w_cnt_inc = {1'b0, r_cnt_rd} + 33'd1;
    assign w_new_cnt = (r_cnt_rd == '1) ? r_cnt_rd : w_cnt_inc[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bvalid <= '0;
            r_rvalid <= '0;
            r_pvld   <= 1'b0;
            for (int k = 0; k < RATE_ENTRIES; k++) begin
                r_rank[k] <= '0;
            end
            for (int k = 0; k < BLOCK_ENTRIES; k++) begin
                r_bflag[k] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_req      <= i_req;
                        r_rsp      <= '0;
                        r_idx      <= '0;
                        r_pvld     <= 1'b0;
                        r_bhit     <= 1'b0;
                        r_bfree_ok <= 1'b0;
                        r_rhit     <= 1'b0;
                        r_rfree_ok <= 1'b0;
                        r_blocked  <= 1'b0;
                        r_used     <= '0;
                        r_oldest   <= '0;
                        r_vict_i   <= '0;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_req.cmd == CmdRead || r_req.cmd == CmdNone) begin
                        if (r_req.cmd == CmdRead) begin
                            r_rsp.counter_value <= w_stat;
                        end
                        r_state <= S_OUT;
                    end else if (r_req.cmd == CmdPacket && (w_parse_err || w_notip)) begin
                        r_rsp.reason <= w_parse_err ? RsnParse : RsnNotIp;
                        r_state      <= S_OUT;
                    end else begin
                        // Entries are fetched into the _q registers and compared in the next cycle.
                        if (r_idx < SW'(NMAX)) begin
                            if (r_idx < SW'(BLOCK_ENTRIES)) begin
                                r_bkey_q  <= r_bkey[w_bi];
                                r_bflag_q <= r_bflag[w_bi];
                            end
                            if (r_idx < SW'(RATE_ENTRIES)) begin
                                r_rkey_q <= r_rkey[w_ri];
                            end
                            r_pidx <= r_idx;
                            r_idx  <= r_idx + SW'(1);
                        end
                        r_pvld <= (r_idx < SW'(NMAX));
                        if (r_pvld) begin
                            if (r_pidx < SW'(BLOCK_ENTRIES)) begin
                                if (r_bvalid[w_pbi] && r_bkey_q == r_req.source_address) begin
                                    if (!r_bhit) begin
                                        r_bhit   <= 1'b1;
                                        r_bhit_i <= w_pbi;
                                        if (r_bflag_q != 8'd0) r_blocked <= 1'b1;
                                    end
                                end else if (!r_bvalid[w_pbi] && !r_bfree_ok) begin
                                    r_bfree_ok <= 1'b1;
                                    r_bfree_i  <= w_pbi;
                                end
                            end
                            if (r_pidx < SW'(RATE_ENTRIES)) begin
                                if (r_rvalid[w_pri]) begin
                                    if (r_rkey_q == r_req.source_address) begin
                                        if (!r_rhit) begin
                                            r_rhit   <= 1'b1;
                                            r_rhit_i <= w_pri;
                                        end
                                    end else begin
                                        r_used <= r_used + RCW'(1);
                                        if (r_rank[w_pri] >= r_oldest) begin
                                            r_oldest <= r_rank[w_pri];
                                            r_vict_i <= w_pri;
                                        end
                                    end
                                end else if (!r_rfree_ok) begin
                                    r_rfree_ok <= 1'b1;
                                    r_rfree_i  <= w_pri;
                                end
                            end
                            if (r_pidx == SW'(NMAX - 1)) begin
                                r_state <= S_RREAD;
                            end
                        end
                    end
                end
                S_RREAD: begin
                    if (r_req.cmd == CmdWrite) begin
                        r_rsp.write_ok <= 1'b1;
                        if (r_bhit) begin
                            if (r_req.block_flag == 8'd0) begin
                                r_bvalid[r_bhit_i] <= 1'b0;
                                r_bflag[r_bhit_i]  <= 8'd0;
                            end else begin
                                r_bflag[r_bhit_i] <= r_req.block_flag;
                            end
                        end else if (r_req.block_flag != 8'd0) begin
                            if (r_bfree_ok) begin
                                r_bvalid[r_bfree_i] <= 1'b1;
                                r_bkey[r_bfree_i]   <= r_req.source_address;
                                r_bflag[r_bfree_i]  <= r_req.block_flag;
                            end else begin
                                r_rsp.write_ok <= 1'b0;
                            end
                        end
                        r_state <= S_OUT;
                    end else if (r_blocked) begin
                        r_rsp.drop   <= 1'b1;
                        r_rsp.reason <= RsnBlocked;
                        r_state      <= S_OUT;
                    end else begin
                        // Pick the entry and its old rank for the recency update.
                        if (r_rhit) begin
                            r_sel      <= r_rhit_i;
                            r_old_rank <= r_rank[r_rhit_i];
                            r_cnt_rd   <= r_rcnt[r_rhit_i];
                            r_ws_rd    <= r_wstart[r_rhit_i];
                        end else if (r_rfree_ok) begin
                            r_sel      <= r_rfree_i;
                            r_old_rank <= r_used[RW-1:0];
                            r_rvalid[r_rfree_i] <= 1'b1;
                        end else begin
                            r_sel      <= r_vict_i;
                            r_old_rank <= r_oldest;
                        end
                        r_idx   <= '0;
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (r_rhit && (w_age < {28'd0, r_window_len})) begin
                        r_rcnt[r_sel] <= w_new_cnt;
                        if (w_new_cnt > r_rate_limit) begin
                            r_rsp.drop   <= 1'b1;
                            r_rsp.reason <= RsnRate;
                        end
                    end else begin
                        r_rcnt[r_sel]   <= 32'd1;
                        r_wstart[r_sel] <= r_req.arrival_time;
                        r_rkey[r_sel]   <= r_req.source_address;
                    end
                    r_state <= S_AGE;
                end
                S_AGE: begin
                    // Age every valid entry younger than the touched one.
                    for (int k = 0; k < RATE_ENTRIES; k++) begin
                        if (RW'(k) == r_sel) begin
                            r_rank[k] <= '0;
                        end else if (r_rvalid[k] && r_rank[k] < r_old_rank) begin
                            r_rank[k] <= r_rank[k] + RW'(1);
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // At most one counter bump per packet, when its result is settled; non-IPv4 frames are not counted.
    always_comb begin
        w_bump     = 1'b0;
        w_bump_sel = StPassed;
        if (r_state == S_SCAN && r_req.cmd == CmdPacket && w_parse_err) begin
            w_bump = 1'b1; w_bump_sel = StParse;
        end else if (r_state == S_RREAD && r_req.cmd == CmdPacket && r_blocked) begin
            w_bump = 1'b1; w_bump_sel = StBlocked;
        end else if (r_state == S_UPD) begin
            w_bump = 1'b1;
            w_bump_sel = (r_rhit && (w_age < {28'd0, r_window_len}) &&
                          (w_new_cnt > r_rate_limit)) ? StRate : StPassed;
        end
    end

    brl_stats u_stats (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_bump    (w_bump),
        .i_bump_sel(w_bump_sel),
        .i_rd_sel  (r_req.counter_select),
        .o_rd_data (w_stat)
    );

    `BRL_ASSERT(a_one_side, i_clk, i_rst_n, !(o_ready && o_valid), "ready while result held")
    `BRL_ASSERT(a_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> (o_valid && $stable(o_rsp)), "result changed while stalled")
    `BRL_ASSERT(a_drop_rsn, i_clk, i_rst_n, o_valid |-> (o_rsp.drop == (o_rsp.reason == RsnBlocked || o_rsp.reason == RsnRate)), "drop and reason disagree")
endmodule
